[design/lsfa_pkg.sv]
// ----------------------------------------------------------------------------
// lsfa_pkg - line slot free list allocator, shared definitions
// Operation and status codes, request and result structs, controller states.
// ----------------------------------------------------------------------------
package lsfa_pkg;

    // Default pool size
    localparam int SLOTS_DEF = 1024;

    // Fixed field widths
    localparam int ID_W    = 10;
    localparam int OWNER_W = 16;
    localparam int COORD_W = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    line_id;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by_coord;
        logic [OWNER_W-1:0] tree_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    slot;
        logic [OWNER_W-1:0] owner;
        logic [COORD_W-1:0] out_ax;
        logic [COORD_W-1:0] out_ay;
        logic [COORD_W-1:0] out_bx;
        logic [COORD_W-1:0] out_by;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

[design/lsfa_ram.sv]
// ----------------------------------------------------------------------------
// lsfa_ram - generic single port RAM
// One access per cycle, a read plus an optional write, read data registered.
// ----------------------------------------------------------------------------
module lsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[design/line_slot_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// line_slot_free_list_allocator - fixed pool of line slots with LIFO free list
// Add, remove, get and clear on a pool of slots, each holding two endpoints
// and an owner tree id.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   --------  ------------------------  --------------------------------
//   request   start, busy (taken when   request (op, line_id, ax, ay,
//             start && !busy)           bx, by_coord, tree_id)
//   result    result_valid, one cycle   result (status, slot, owner,
//                                       out_ax, out_ay, out_bx, out_by)
//
// Every request takes two cycles: the slot row is read from the single port
// slot RAM in the accept cycle and written back in the execute cycle, while
// busy is high. The result strobes in the cycle after execute; a new request
// may be taken in that same cycle, so the sustained rate is one per 2 cycles.
// Reset empties the free list and the fresh pointer; the RAM is not cleared.
// A slot is live only below the fresh pointer and with its alive bit set.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module line_slot_free_list_allocator #(
    parameter int SLOTS = lsfa_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lsfa_pkg::req_t request,
    output logic          result_valid,
    output lsfa_pkg::rsp_t result
);

    import lsfa_pkg::*;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int PTR_W    = $clog2(SLOTS + 1);
    localparam int EP_W     = 4 * COORD_W;
    localparam int OWN_LSB  = EP_W;
    localparam int LINK_LSB = OWN_LSB + OWNER_W;
    localparam int ALIVE    = LINK_LSB + IDX_W;
    localparam int ROW_W    = ALIVE + 1;

    // Control and pointer state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               head_vld_reg, head_vld_next;
    logic [PTR_W-1:0]   fresh_reg, fresh_next;
    logic               done_reg, done_next;

    // Payload registers
    req_t               req_reg;
    rsp_t               rsp_reg, rsp_next;

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ROW_W-1:0]   wr_row;
    logic [ROW_W-1:0]   rd_row;
    logic [IDX_W-1:0]   wr_addr;

    logic               accept;
    logic [IDX_W-1:0]   id_idx;
    logic [IDX_W-1:0]   rd_link;
    logic               rd_alive;
    logic               id_live;

    assign accept   = start && !busy;
    assign id_idx   = IDX_W'(req_reg.line_id);
    assign rd_link  = rd_row[LINK_LSB +: IDX_W];
    assign rd_alive = rd_row[ALIVE];
    // live: allocated since the last clear and not released since
    assign id_live  = (32'(req_reg.line_id) < 32'(fresh_reg)) && rd_alive;

    // Slot rows: alive, free link, owner, endpoints
    lsfa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_row),
        .rdata (rd_row)
    );

    // State and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            head_vld_reg <= 1'b0;
            fresh_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            head_vld_reg <= head_vld_next;
            fresh_reg    <= fresh_next;
            done_reg     <= done_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (state_reg == ST_EXEC)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Sequencer: read in the accept cycle, write back in execute
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done_next  = 1'b0;
        ram_addr   = (request.op == OP_ADD) ? head_reg : IDX_W'(request.line_id);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                done_next  = 1'b1;
                ram_addr   = wr_addr;
                state_next = ST_IDLE;
            end
        endcase
    end

    // Execute: pointer update, row write back and result
    always_comb
    begin
        logic [IDX_W-1:0] alloc;

        alloc         = head_reg;
        head_next     = head_reg;
        head_vld_next = head_vld_reg;
        fresh_next    = fresh_reg;
        ram_we        = 1'b0;
        wr_addr       = id_idx;
        wr_row        = rd_row;
        rsp_next          = '0;
        rsp_next.status   = STAT_OK;
        rsp_next.slot     = req_reg.line_id;

        if (state_reg == ST_EXEC)
        begin
            case (req_reg.op) inside
                OP_ADD:
                begin
                    ram_we = 1'b1;
                    if (head_vld_reg)
                    begin
                        // pop; a self link ends the list
                        alloc = head_reg;
                        if (rd_link == head_reg)
                        begin
                            head_vld_next = 1'b0;
                        end
                        else
                        begin
                            head_next = rd_link;
                        end
                    end
                    else if (32'(fresh_reg) < 32'(SLOTS))
                    begin
                        alloc      = fresh_reg[IDX_W-1:0];
                        fresh_next = fresh_reg + PTR_W'(1);
                    end
                    else
                    begin
                        ram_we          = 1'b0;
                        rsp_next.status = STAT_FULL;
                        alloc           = '0;
                    end
                    wr_addr                 = alloc;
                    wr_row[ALIVE]           = 1'b1;
                    wr_row[OWN_LSB +: OWNER_W] = req_reg.tree_id;
                    wr_row[EP_W-1:0]        = {req_reg.ax, req_reg.ay,
                                               req_reg.bx, req_reg.by_coord};
                    rsp_next.slot           = ID_W'(alloc);
                end
                OP_REMOVE, OP_GET:
                begin
                    if (!id_live)
                    begin
                        rsp_next.status = STAT_INVALID;
                    end
                    else
                    begin
                        rsp_next.owner = rd_row[OWN_LSB +: OWNER_W];
                        if (req_reg.op == OP_REMOVE)
                        begin
                            // push onto the free list
                            ram_we                     = 1'b1;
                            wr_row[ALIVE]              = 1'b0;
                            wr_row[LINK_LSB +: IDX_W]  = head_vld_reg ? head_reg : id_idx;
                            head_next                  = id_idx;
                            head_vld_next              = 1'b1;
                        end
                        else
                        begin
                            rsp_next.out_ax = rd_row[3*COORD_W +: COORD_W];
                            rsp_next.out_ay = rd_row[2*COORD_W +: COORD_W];
                            rsp_next.out_bx = rd_row[COORD_W +: COORD_W];
                            rsp_next.out_by = rd_row[0 +: COORD_W];
                        end
                    end
                end
                default:
                begin
                    // clear all
                    head_vld_next = 1'b0;
                    fresh_next    = '0;
                end
            endcase
        end
    end

    assign result_valid = done_reg;
    assign result       = rsp_reg;

endmodule

[test/line_slot_free_list_allocator_test.sv]
// ----------------------------------------------------------------------------
// line_slot_free_list_allocator_test - self-checking bench for the allocator
// A short table of directed requests covers empty-pool reads, extreme
// coordinates, LIFO reuse, double remove and clear. Random requests then
// churn the pool and fill it until it reports full. Every result is compared
// with its table answer or an in-bench model of the slot pool and free list.
// ----------------------------------------------------------------------------
module line_slot_free_list_allocator_test;

    import lsfa_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int GAP_CAP    = 40;
    localparam int FULL_TURNS = 6;

    // One row of the directed table
    typedef struct {
        req_t cmd;
        bit   typed;
        rsp_t answer;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    // Pool model: slot contents, free list and allocation pointers
    logic [COORD_W-1:0] ax_mem    [SLOTS];
    logic [COORD_W-1:0] ay_mem    [SLOTS];
    logic [COORD_W-1:0] bx_mem    [SLOTS];
    logic [COORD_W-1:0] by_mem    [SLOTS];
    logic [OWNER_W-1:0] owner_mem [SLOTS];
    logic [ID_W-1:0]    link_mem  [SLOTS];
    bit                 live      [SLOTS];
    int                 free_top   = SLOTS;
    int                 fresh_next = 0;
    int                 live_count = 0;

    rsp_t      pending_responses [$];
    plan_row_t plan [$];
    rsp_t      oldest;

    int mismatches   = 0;
    int cycles       = 0;
    int idle_pct     = 0;
    int adds_done    = 0;
    int full_hits    = 0;
    int invalid_hits = 0;
    int list_pops    = 0;
    int clears_done  = 0;
    int requests     = 0;

    line_slot_free_list_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_responses.size());
            $display("line_slot_free_list_allocator_test failed");
            $finish;
        end
    end

    // Model of one request: updates the pool and gives the expected result
    task automatic compute_pool_response(input req_t r, output rsp_t o);
        logic [ID_W-1:0] s;
        bit              got;
        begin
            o        = '0;
            o.status = STAT_OK;
            o.slot   = r.line_id;
            got      = 1'b1;
            s        = '0;
            case (r.op) inside
                OP_ADD:
                begin
                    // free list first, then the next never-used slot
                    if (free_top < SLOTS)
                    begin
                        s        = free_top[ID_W-1:0];
                        free_top = (link_mem[s] == s) ? SLOTS : int'(link_mem[s]);
                        list_pops++;
                    end
                    else if (fresh_next < SLOTS)
                    begin
                        s = fresh_next[ID_W-1:0];
                        fresh_next++;
                    end
                    else
                        got = 1'b0;
                    if (got)
                    begin
                        ax_mem[s]    = r.ax;
                        ay_mem[s]    = r.ay;
                        bx_mem[s]    = r.bx;
                        by_mem[s]    = r.by_coord;
                        owner_mem[s] = r.tree_id;
                        live[s]      = 1'b1;
                        live_count++;
                        adds_done++;
                        o.slot = s;
                    end
                    else
                    begin
                        o.status = STAT_FULL;
                        o.slot   = '0;
                        full_hits++;
                    end
                end
                OP_REMOVE, OP_GET:
                begin
                    if (!live[r.line_id])
                    begin
                        o.status = STAT_INVALID;
                        invalid_hits++;
                    end
                    else
                    begin
                        o.owner = owner_mem[r.line_id];
                        if (r.op == OP_REMOVE)
                        begin
                            // push; the last entry of the list links to itself
                            live[r.line_id]     = 1'b0;
                            live_count--;
                            link_mem[r.line_id] = (free_top < SLOTS) ?
                                                  free_top[ID_W-1:0] : r.line_id;
                            free_top            = int'(r.line_id);
                        end
                        else
                        begin
                            o.out_ax = ax_mem[r.line_id];
                            o.out_ay = ay_mem[r.line_id];
                            o.out_bx = bx_mem[r.line_id];
                            o.out_by = by_mem[r.line_id];
                        end
                    end
                end
                default:
                begin
                    foreach (live[k])
                        live[k] = 1'b0;
                    free_top   = SLOTS;
                    fresh_next = 0;
                    live_count = 0;
                    clears_done++;
                end
            endcase
        end
    endtask

    // Random slot that is currently allocated, or -1 if none
    function automatic int pick_live_slot();
        int base;
        begin
            if (live_count == 0)
                return -1;
            base = $urandom_range(SLOTS - 1);
            for (int k = 0; k < SLOTS; k++)
                if (live[(base + k) % SLOTS])
                    return (base + k) % SLOTS;
            return -1;
        end
    endfunction

    // Random request; filling mode favours add and never clears
    task automatic make_random_request(input bit filling, output req_t r);
        int roll;
        int pick;
        begin
            r.line_id  = ID_W'($urandom_range(SLOTS - 1));
            r.ax       = $urandom();
            r.ay       = $urandom();
            r.bx       = $urandom();
            r.by_coord = $urandom();
            r.tree_id  = OWNER_W'($urandom_range(16'hFFFF));
            roll       = $urandom_range(99);
            if (filling)
                r.op = (roll < 98) ? OP_ADD : (roll < 99) ? OP_REMOVE : OP_GET;
            else
                r.op = (roll < 40) ? OP_ADD : (roll < 65) ? OP_REMOVE :
                       (roll < 96) ? OP_GET : OP_CLEAR;
            // mostly aim remove and get at live slots
            if ((r.op == OP_REMOVE || r.op == OP_GET) && $urandom_range(9) < 8)
            begin
                pick = pick_live_slot();
                if (pick >= 0)
                    r.line_id = pick[ID_W-1:0];
            end
        end
    endtask

    // Present one request, wait for it to be taken, record the expectation
    task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp);
        int   gap;
        rsp_t predicted;
        begin
            gap = 0;
            while (gap < GAP_CAP && $urandom_range(99) < idle_pct)
                gap++;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start   <= 1'b1;
            request <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            compute_pool_response(r, predicted);
            pending_responses.push_back(typed ? typed_rsp : predicted);
            requests++;
        end
    endtask

    task automatic add_row(input op_t op, input int id,
                           input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] bx, input logic [31:0] by,
                           input logic [15:0] tree, input bit typed,
                           input status_t st, input int slot, input logic [15:0] own,
                           input logic [31:0] oax, input logic [31:0] oay,
                           input logic [31:0] obx, input logic [31:0] oby);
        plan_row_t p;
        begin
            p.cmd.op          = op;
            p.cmd.line_id     = id[ID_W-1:0];
            p.cmd.ax          = ax;
            p.cmd.ay          = ay;
            p.cmd.bx          = bx;
            p.cmd.by_coord    = by;
            p.cmd.tree_id     = tree;
            p.typed           = typed;
            p.answer.status   = st;
            p.answer.slot     = slot[ID_W-1:0];
            p.answer.owner    = own;
            p.answer.out_ax   = oax;
            p.answer.out_ay   = oay;
            p.answer.out_bx   = obx;
            p.answer.out_by   = oby;
            plan.push_back(p);
        end
    endtask

    task automatic field_check(input string name, input logic [31:0] e,
                               input logic [31:0] a);
        if (e !== a)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
        end
    endtask

    task automatic check_result(input rsp_t e, input rsp_t a);
        begin
            field_check("status", 32'(e.status), 32'(a.status));
            field_check("slot",   32'(e.slot),   32'(a.slot));
            field_check("owner",  32'(e.owner),  32'(a.owner));
            field_check("out_ax", e.out_ax, a.out_ax);
            field_check("out_ay", e.out_ay, a.out_ay);
            field_check("out_bx", e.out_bx, a.out_bx);
            field_check("out_by", e.out_by, a.out_by);
        end
    endtask

    // Result monitor: one strobe, one result, checked against the oldest
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, got %h", $time, result);
            end
            else
            begin
                oldest = pending_responses.pop_front();
                check_result(oldest, result);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        req_t r;
        int   n;

        // directed table; typed answers only where obvious
        // empty pool: reads and removes are refused
        add_row(OP_GET,    0,    0, 0, 0, 0, 0, 1, STAT_INVALID, 0,    0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 1023, 0, 0, 0, 0, 0, 1, STAT_INVALID, 1023, 0, 0, 0, 0, 0);
        // fresh allocation with coordinate extremes
        add_row(OP_ADD, 1023, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF,
                1, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 0, '1, '1, '1, '1, 16'h0000, 1, STAT_OK, 1, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 341, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001, 32'h7FFF_FFFE,
                16'h8001, 1, STAT_OK, 2, 0, 0, 0, 0, 0);
        add_row(OP_GET, 0, 0, 0, 0, 0, 0, 1, STAT_OK, 0, 16'hFFFF,
                32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        add_row(OP_GET, 1, 0, 0, 0, 0, 0, 1, STAT_OK, 1, 16'h0000, '1, '1, '1, '1);
        // release and LIFO reuse
        add_row(OP_REMOVE, 1, 0, 0, 0, 0, 0, 1, STAT_OK, 1, 16'h0000, 0, 0, 0, 0);
        add_row(OP_GET,    1, 0, 0, 0, 0, 0, 1, STAT_INVALID, 1, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 0, 0, 0, 0, 0, 0, 1, STAT_OK, 0, 16'hFFFF, 0, 0, 0, 0);
        add_row(OP_REMOVE, 0, 0, 0, 0, 0, 0, 1, STAT_INVALID, 0, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 7, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                16'h0F0F, 1, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 7, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0000_FFFF, 32'hFFFF_0000,
                16'hF0F0, 1, STAT_OK, 1, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 7, 32'h1111_1111, 32'h2222_2222, 32'h4444_4444, 32'h8888_8888,
                16'h5555, 1, STAT_OK, 3, 0, 0, 0, 0, 0);
        add_row(OP_GET,    3, 0, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 2, 0, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_ADD, 0, 32'h3333_3333, 32'h6666_6666, 32'hCCCC_CCCC, 32'h9999_9999,
                16'hAAAA, 0, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_GET,    2, 0, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0, 0, 0, 0);
        // clear echoes the index and empties the pool
        add_row(OP_CLEAR, 682, '1, '1, '1, '1, '1, 1, STAT_OK, 682, 0, 0, 0, 0, 0);
        add_row(OP_GET,   0, 0, 0, 0, 0, 0, 1, STAT_INVALID, 0, 0, 0, 0, 0, 0);
        add_row(OP_ADD,   0, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                16'h7FFF, 1, STAT_OK, 0, 0, 0, 0, 0, 0);
        add_row(OP_GET,   0, 0, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0, 0, 0, 0);

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, light sender idling
        idle_pct = 11;
        foreach (plan[i])
            issue(plan[i].cmd, plan[i].typed, plan[i].answer);

        // random churn, light then heavy sender idling
        for (n = 0; n < 40; n++)
        begin
            make_random_request(1'b0, r);
            issue(r, 1'b0, '0);
        end
        idle_pct = 61;
        for (n = 0; n < 40; n++)
        begin
            make_random_request(1'b0, r);
            issue(r, 1'b0, '0);
        end

        // back to back: fill the pool until it refuses adds, then churn
        idle_pct = 0;
        n = full_hits;
        while (full_hits < n + FULL_TURNS)
        begin
            make_random_request(1'b1, r);
            issue(r, 1'b0, '0);
        end
        for (n = 0; n < 20; n++)
        begin
            make_random_request(1'b0, r);
            issue(r, 1'b0, '0);
        end
        start <= 1'b0;

        // drain
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("%0d requests: %0d adds placed, %0d reused from the free list, %0d clears",
                 requests, adds_done, list_pops, clears_done);
        $display("pool full seen %0d times, unallocated slot refused %0d times",
                 full_hits, invalid_hits);
        if (mismatches == 0)
            $display("line_slot_free_list_allocator_test passed");
        else
            $display("line_slot_free_list_allocator_test failed");
        $finish;
    end

endmodule
